/* sv/cdtk_pkg.sv */
// Shared types, constants and the month-length function of the calendar keeper.
`timescale 1ns / 1ps
`default_nettype none
package cdtk_pkg;

    // Operation codes carried in the op field of a request beat.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_ADD_DAYS  = 3'd1;
    localparam logic [2:0] OP_SET_DATE  = 3'd2;
    localparam logic [2:0] OP_SET_TIME  = 3'd3;
    localparam logic [2:0] OP_CLR_FLAGS = 3'd4;
    localparam logic [2:0] OP_SET_FLAGS = 3'd5;

    localparam logic [4:0]  LAST_HOUR       = 5'd23;
    localparam logic [5:0]  LAST_MINUTE     = 6'd59;
    localparam logic [5:0]  LAST_SECOND     = 6'd59;
    localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;
    localparam logic [4:0]  FEB_LEAP_DAYS   = 5'd29;
    localparam logic [4:0]  FEB_PLAIN_DAYS  = 5'd28;
    localparam logic [4:0]  LONG_MONTH_DAYS = 5'd31;
    localparam logic [3:0]  FEBRUARY        = 4'd2;
    localparam logic [15:0] ALL_FLAGS       = 16'hFFFF;

    localparam logic [4:0] MONTH_DAYS [0:12] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  day_count;
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [6:0]  new_year;
        logic [4:0]  new_hour;
        logic [5:0]  new_minute;
        logic [5:0]  new_second;
        logic [15:0] flag_mask;
    } req_item_t;

    typedef struct packed {
        logic [4:0]  day_now;
        logic [3:0]  month_now;
        logic [6:0]  year_now;
        logic [4:0]  hour_now;
        logic [5:0]  minute_now;
        logic [5:0]  second_now;
        logic [15:0] flags_now;
        logic        day_changed;
    } rsp_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_RESULT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic walk;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic need_walk;
        logic walk_done;
    } dp_status_t;

    // Length of the given month; February follows the leap rule of the year.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] len;
        if (month == FEBRUARY) begin
            len = (year[1:0] == 2'b00) ? FEB_LEAP_DAYS : FEB_PLAIN_DAYS;
        end
        else if (month >= 4'd1 && month <= MONTHS_PER_YEAR) begin
            len = MONTH_DAYS[month];
        end
        else begin
            len = LONG_MONTH_DAYS;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

/* sv/cdtk_req_if.sv */
// Request channel interface of the calendar keeper.
`timescale 1ns / 1ps
`default_nettype none
interface cdtk_req_if;
    logic                 valid;
    logic                 ready;
    cdtk_pkg::req_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

/* sv/cdtk_rsp_if.sv */
// Response channel interface of the calendar keeper.
`timescale 1ns / 1ps
`default_nettype none
interface cdtk_rsp_if;
    logic                 valid;
    logic                 ready;
    cdtk_pkg::rsp_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

/* sv/cdtk_ctrl.sv */
// Controller state machine of the calendar keeper.
`timescale 1ns / 1ps
`default_nettype none
module cdtk_ctrl (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     req_valid,
    output logic                    req_ready,
    output logic                    rsp_valid,
    input  wire                     rsp_ready,
    output cdtk_pkg::ctrl_cmd_t     cmd,
    input  cdtk_pkg::dp_status_t    status
);
    import cdtk_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = status.need_walk ? ST_WALK : ST_RESULT;
                end
            end
            ST_WALK:
            begin
                if (status.walk_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.load  = req_valid;
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
            end
            ST_RESULT:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* sv/cdtk_dpath.sv */
// Datapath of the calendar keeper: time, date, flag registers and the month walker.
`timescale 1ns / 1ps
`default_nettype none
module cdtk_dpath (
    input  wire                     clk,
    input  wire                     rst_n,
    input  cdtk_pkg::req_item_t     req_item,
    input  cdtk_pkg::ctrl_cmd_t     cmd,
    output cdtk_pkg::dp_status_t    status,
    output cdtk_pkg::rsp_item_t     rsp_item
);
    import cdtk_pkg::*;

    logic [5:0]  sec_reg,   sec_next;
    logic [5:0]  min_reg,   min_next;
    logic [4:0]  hour_reg,  hour_next;
    logic [4:0]  day_reg,   day_next;
    logic [3:0]  month_reg, month_next;
    logic [6:0]  year_reg,  year_next;
    logic [15:0] flags_reg, flags_next;

    // Date as it stood before the current item, for the change indication.
    logic [4:0]  prev_day_reg,   prev_day_next;
    logic [3:0]  prev_month_reg, prev_month_next;
    logic [6:0]  prev_year_reg,  prev_year_next;

    // Running day count of the month walk and whether the walk sets the flags.
    logic [8:0]  walk_day_reg,   walk_day_next;
    logic        walk_flags_reg, walk_flags_next;

    logic [4:0]  cur_len;
    logic        day_wrap;

    assign cur_len  = month_len(month_reg, year_reg);
    assign day_wrap = (sec_reg == LAST_SECOND) && (min_reg == LAST_MINUTE)
                      && (hour_reg == LAST_HOUR);

    always_comb
    begin
        status.need_walk = (req_item.op == OP_ADD_DAYS) || ((req_item.op == OP_TICK) && day_wrap);
        status.walk_done = (walk_day_reg <= {4'd0, cur_len});
    end

    always_comb
    begin
        sec_next        = sec_reg;
        min_next        = min_reg;
        hour_next       = hour_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        flags_next      = flags_reg;
        prev_day_next   = prev_day_reg;
        prev_month_next = prev_month_reg;
        prev_year_next  = prev_year_reg;
        walk_day_next   = walk_day_reg;
        walk_flags_next = walk_flags_reg;

        if (cmd.load)
        begin
            prev_day_next   = day_reg;
            prev_month_next = month_reg;
            prev_year_next  = year_reg;
            unique case (req_item.op)
                OP_TICK:
                begin
                    if (sec_reg != LAST_SECOND)
                    begin
                        sec_next = sec_reg + 6'd1;
                    end
                    else
                    begin
                        sec_next = '0;
                        if (min_reg != LAST_MINUTE)
                        begin
                            min_next = min_reg + 6'd1;
                        end
                        else
                        begin
                            min_next = '0;
                            if (hour_reg != LAST_HOUR)
                            begin
                                hour_next = hour_reg + 5'd1;
                            end
                            else
                            begin
                                hour_next       = '0;
                                walk_day_next   = {4'd0, day_reg} + 9'd1;
                                walk_flags_next = 1'b1;
                            end
                        end
                    end
                end
                OP_ADD_DAYS:
                begin
                    walk_day_next   = {4'd0, day_reg} + {1'b0, req_item.day_count};
                    walk_flags_next = (req_item.day_count != 8'd0);
                end
                OP_SET_DATE:
                begin
                    day_next   = (req_item.new_day == 5'd0) ? 5'd1 : req_item.new_day;
                    month_next = (req_item.new_month == 4'd0
                                  || req_item.new_month > MONTHS_PER_YEAR)
                                 ? 4'd1 : req_item.new_month;
                    year_next  = req_item.new_year;
                end
                OP_SET_TIME:
                begin
                    hour_next = (req_item.new_hour > LAST_HOUR) ? LAST_HOUR : req_item.new_hour;
                    min_next  = (req_item.new_minute > LAST_MINUTE)
                                ? LAST_MINUTE : req_item.new_minute;
                    sec_next  = (req_item.new_second > LAST_SECOND)
                                ? LAST_SECOND : req_item.new_second;
                end
                OP_CLR_FLAGS:
                begin
                    flags_next = flags_reg & ~req_item.flag_mask;
                end
                OP_SET_FLAGS:
                begin
                    flags_next = flags_reg | req_item.flag_mask;
                end
                default:
                begin
                    flags_next = flags_reg;
                end
            endcase
        end
        else if (cmd.walk)
        begin
            if (walk_day_reg > {4'd0, cur_len})
            begin
                walk_day_next = walk_day_reg - {4'd0, cur_len};
                if (month_reg >= MONTHS_PER_YEAR)
                begin
                    month_next = 4'd1;
                    year_next  = year_reg + 7'd1;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
            else
            begin
                day_next = walk_day_reg[4:0];
                if (walk_flags_reg)
                begin
                    flags_next = ALL_FLAGS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= '0;
            min_reg   <= '0;
            hour_reg  <= '0;
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= '0;
            flags_reg <= '0;
        end
        else
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hour_reg  <= hour_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_day_reg   <= prev_day_next;
        prev_month_reg <= prev_month_next;
        prev_year_reg  <= prev_year_next;
        walk_day_reg   <= walk_day_next;
        walk_flags_reg <= walk_flags_next;
    end

    always_comb
    begin
        rsp_item.day_now     = day_reg;
        rsp_item.month_now   = month_reg;
        rsp_item.year_now    = year_reg;
        rsp_item.hour_now    = hour_reg;
        rsp_item.minute_now  = min_reg;
        rsp_item.second_now  = sec_reg;
        rsp_item.flags_now   = flags_reg;
        rsp_item.day_changed = (prev_day_reg != day_reg) || (prev_month_reg != month_reg)
                               || (prev_year_reg != year_reg);
    end

endmodule
`default_nettype wire

/* sv/calendar_date_time_keeper.sv */
// Most operations present their response beat in the cycle after the request beat is
// taken; a day advance (add days, or a tick at midnight) first runs the month walker.
// One item at a time: no new request is taken until the response has been accepted;
// the month walker sets how long a day advance takes.
// Reset (rst_n, asynchronous, active low): time 00:00:00, date day 1 month 1 year 0,
// flags clear, no response pending.
`timescale 1ns / 1ps
`default_nettype none
module calendar_date_time_keeper (
    input  wire          clk,
    input  wire          rst_n,
    cdtk_req_if.sink     req,
    cdtk_rsp_if.source   rsp
);
    import cdtk_pkg::*;

    // The controller sequences each beat: it loads the request into the
    // datapath, steps the month walker while a day advance is still in
    // progress, and then presents the response until it is taken.
    ctrl_cmd_t  cmd;
    dp_status_t status;
    rsp_item_t  rsp_item;

    cdtk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath keeps the time as separate hour, minute and second
    // counters, so the reported fields come straight from registers. A day
    // advance walks one month per cycle, always using the length of the
    // month and year held at that moment.
    cdtk_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_item (req.item),
        .cmd      (cmd),
        .status   (status),
        .rsp_item (rsp_item)
    );

    // The response fields are held in the state registers and do not move
    // while the response beat waits.
    assign rsp.item = rsp_item;

endmodule
`default_nettype wire

/* sv/cdtk_checker.sv */
// Port-level assertions of the calendar keeper and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cdtk_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   req_valid,
    input wire                   req_ready,
    input wire                   rsp_valid,
    input wire                   rsp_ready,
    input cdtk_pkg::rsp_item_t   rsp_item
);
    import cdtk_pkg::*;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !req_ready)
        else $error("request accepted while a response is pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request channel ready straight after a beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_item)))
        else $error("stalled response changed");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.hour_now <= LAST_HOUR && rsp_item.minute_now <= LAST_MINUTE
                       && rsp_item.second_now <= LAST_SECOND && rsp_item.month_now >= 4'd1
                       && rsp_item.month_now <= MONTHS_PER_YEAR))
        else $error("reported time or month out of range");

endmodule

bind calendar_date_time_keeper cdtk_checker u_cdtk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_item  (rsp.item)
);
`default_nettype wire

/* tb/tb_calendar_date_time_keeper.sv */
// Self-checking testbench of the calendar date and time keeper.
`timescale 1ns / 1ps
module tb_calendar_date_time_keeper;
    import cdtk_pkg::*;

    // Op codes that the block does not use; such beats must leave the state alone.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MINUTE = 60;
    localparam int YEARS_WRAP      = 128;

    // Cycles allowed after the last response so that a late walk can still show up.
    localparam int SETTLE_CYCLES = 40;
    // Length of the long receiver hold-off that backs the block up.
    localparam int HOLD_CYCLES   = 300;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cdtk_req_if req_ch ();
    cdtk_rsp_if rsp_ch ();

    calendar_date_time_keeper u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // A generous ceiling on the whole run; a correct run ends far sooner.
    initial
    begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Calendar predictor. It keeps its own copy of the time, the date and
    // the flag word, and works out the status that each request beat
    // should produce. It is updated in the same order as the block
    // accepts beats, so the expected statuses queue up in arrival order.
    // ------------------------------------------------------------------
    int          clock_secs = 0;
    int          cal_day    = 1;
    int          cal_month  = 1;
    int          cal_year   = 0;
    logic [15:0] day_flags  = '0;

    rsp_item_t pending_status [$];
    int        mismatch_count = 0;

    // Idling percentages of the two sides. A hold-off is requested by
    // bumping hold_requests; the receiver notices the change and counts
    // the stretch down itself.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    function automatic int days_in_month(int month, int year);
        if (month == FEBRUARY) begin
            return (year % 4 == 0) ? FEB_LEAP_DAYS : FEB_PLAIN_DAYS;
        end
        case (month)
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Moves the date on by a number of days. A day stored beyond the end of
    // its month is folded into the following months here, even for a count
    // of zero; only a real advance raises every new-day flag.
    function automatic void walk_days(int count);
        int d;
        d = cal_day + count;
        while (d > days_in_month(cal_month, cal_year)) begin
            d -= days_in_month(cal_month, cal_year);
            cal_month++;
            if (cal_month > MONTHS_PER_YEAR) begin
                cal_month = 1;
                cal_year  = (cal_year + 1) % YEARS_WRAP;
            end
        end
        cal_day = d;
        if (count > 0) begin
            day_flags = ALL_FLAGS;
        end
    endfunction

    function automatic rsp_item_t step_calendar(req_item_t q);
        rsp_item_t r;
        int        pd;
        int        pm;
        int        py;
        int        h;
        int        mi;
        int        s;
        pd = cal_day;
        pm = cal_month;
        py = cal_year;
        case (q.op)
            OP_TICK:
            begin
                clock_secs++;
                if (clock_secs >= SECS_PER_DAY) begin
                    clock_secs = 0;
                    walk_days(1);
                end
            end
            OP_ADD_DAYS:
            begin
                walk_days(q.day_count);
            end
            OP_SET_DATE:
            begin
                // Day 0 and an impossible month are pulled back to 1.
                cal_day   = (q.new_day == 0) ? 1 : q.new_day;
                cal_month = (q.new_month == 0 || q.new_month > MONTHS_PER_YEAR)
                            ? 1 : q.new_month;
                cal_year  = q.new_year;
            end
            OP_SET_TIME:
            begin
                // Fields beyond their last legal value saturate.
                h  = (q.new_hour > LAST_HOUR) ? LAST_HOUR : q.new_hour;
                mi = (q.new_minute > LAST_MINUTE) ? LAST_MINUTE : q.new_minute;
                s  = (q.new_second > LAST_SECOND) ? LAST_SECOND : q.new_second;
                clock_secs = h * SECS_PER_HOUR + mi * SECS_PER_MINUTE + s;
            end
            OP_CLR_FLAGS:
            begin
                day_flags = day_flags & ~q.flag_mask;
            end
            OP_SET_FLAGS:
            begin
                day_flags = day_flags | q.flag_mask;
            end
            default:
            begin
            end
        endcase
        r.day_now     = 5'(cal_day);
        r.month_now   = 4'(cal_month);
        r.year_now    = 7'(cal_year);
        r.hour_now    = 5'(clock_secs / SECS_PER_HOUR);
        r.minute_now  = 6'((clock_secs % SECS_PER_HOUR) / SECS_PER_MINUTE);
        r.second_now  = 6'(clock_secs % SECS_PER_MINUTE);
        r.flags_now   = day_flags;
        r.day_changed = (pd != cal_day || pm != cal_month || py != cal_year);
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor and scoreboard. Both channels are sampled at the rising
    // edge, before any of the nonblocking updates of that edge land, so
    // the values seen are the ones the handshake really carried. The
    // request side is handled first so that a prediction is always in
    // the queue before its response could possibly be looked at.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : status_monitor
        rsp_item_t want;
        rsp_item_t got;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                pending_status.push_back(step_calendar(req_ch.item));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.item;
                if (pending_status.size() == 0) begin
                    $display("%0t ns: unexpected status beat, expected none, actual %h",
                             $time, got);
                    mismatch_count++;
                end
                else begin
                    want = pending_status.pop_front();
                    check_field("day_now",     want.day_now,     got.day_now);
                    check_field("month_now",   want.month_now,   got.month_now);
                    check_field("year_now",    want.year_now,    got.year_now);
                    check_field("hour_now",    want.hour_now,    got.hour_now);
                    check_field("minute_now",  want.minute_now,  got.minute_now);
                    check_field("second_now",  want.second_now,  got.second_now);
                    check_field("flags_now",   want.flags_now,   got.flags_now);
                    check_field("day_changed", want.day_changed, got.day_changed);
                end
            end
        end
    end

    // Receiver: a long hold-off when one is requested, otherwise random
    // back-pressure at the current rate.
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
        end
        else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // A request with every field random, so that fields which the op
    // ignores still toggle; the caller then fills in what matters.
    function automatic req_item_t base_item(logic [2:0] op);
        req_item_t   q;
        logic [63:0] raw;
        raw  = {$urandom, $urandom};
        q    = raw[59:0];
        q.op = op;
        return q;
    endfunction

    // Offers one beat after a random gap and returns at the edge where it
    // is taken. The valid line is left high so a following beat can go
    // straight out on the next cycle.
    task automatic send_item(input req_item_t q);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item  <= q;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    // Stops offering and waits until every predicted status has arrived.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_status.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic send_set_time(int h, int m, int s);
        req_item_t q;
        q            = base_item(OP_SET_TIME);
        q.new_hour   = 5'(h);
        q.new_minute = 6'(m);
        q.new_second = 6'(s);
        send_item(q);
    endtask

    task automatic send_set_date(int d, int m, int y);
        req_item_t q;
        q           = base_item(OP_SET_DATE);
        q.new_day   = 5'(d);
        q.new_month = 4'(m);
        q.new_year  = 7'(y);
        send_item(q);
    endtask

    task automatic send_add_days(int n);
        req_item_t q;
        q           = base_item(OP_ADD_DAYS);
        q.day_count = 8'(n);
        send_item(q);
    endtask

    task automatic send_flag_op(logic [2:0] op, logic [15:0] mask);
        req_item_t q;
        q           = base_item(op);
        q.flag_mask = mask;
        send_item(q);
    endtask

    // Random traffic is mostly well-formed: plenty of ticks, with the time
    // often set just short of midnight so that the rollover into the next
    // day is reached often, plus day advances, date loads, flag work and unused op codes.
    // A share of the loads carry raw field values, out-of-range ones included.
    function automatic req_item_t random_request();
        req_item_t q;
        int        pick;
        q    = base_item(OP_TICK);
        pick = $urandom_range(99);
        if (pick < 45) begin
            q.op = OP_TICK;
        end
        else if (pick < 55) begin
            q.op = OP_SET_TIME;
            if ($urandom_range(3) != 0) begin
                q.new_hour   = LAST_HOUR;
                q.new_minute = LAST_MINUTE;
                q.new_second = 6'($urandom_range(59, 54));
            end
        end
        else if (pick < 68) begin
            q.op = OP_ADD_DAYS;
            case ($urandom_range(3))
                0:       q.day_count = q.day_count;
                1:       q.day_count = 8'($urandom_range(255, 200));
                default: q.day_count = 8'($urandom_range(40));
            endcase
        end
        else if (pick < 78) begin
            q.op = OP_SET_DATE;
            if ($urandom_range(3) != 0) begin
                q.new_day   = 5'($urandom_range(31, 1));
                q.new_month = 4'($urandom_range(12, 1));
            end
        end
        else if (pick < 87) begin
            q.op = OP_CLR_FLAGS;
        end
        else if (pick < 97) begin
            q.op = OP_SET_FLAGS;
        end
        else begin
            q.op = ($urandom_range(1) == 1) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return q;
    endfunction

    task automatic run_random(int count);
        repeat (count) begin
            send_item(random_request());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Directed corners: the midnight rollover, flag handling, leap and
    // plain February, a day beyond the month's end being normalised by a
    // zero-day advance, the year wrapping after 127, out-of-range date and
    // time loads, the largest advance and the unused op codes.
    task automatic test_directed();
        send_item(base_item(OP_TICK));
        send_set_time(23, 59, 59);
        send_item(base_item(OP_TICK));
        send_flag_op(OP_CLR_FLAGS, 16'hFFFF);
        send_flag_op(OP_SET_FLAGS, 16'h8001);
        send_flag_op(OP_SET_FLAGS, 16'hAAAA);
        send_flag_op(OP_CLR_FLAGS, 16'h5555);
        send_flag_op(OP_CLR_FLAGS, 16'hFFFF);
        send_add_days(0);
        send_set_date(29, 2, 0);
        send_add_days(1);
        send_set_date(31, 2, 1);
        send_add_days(0);
        send_set_date(31, 12, 127);
        send_set_time(23, 59, 59);
        send_item(base_item(OP_TICK));
        send_add_days(255);
        send_set_date(0, 0, 127);
        send_set_date(31, 15, 64);
        send_add_days(255);
        send_set_date(5, 13, 3);
        send_set_time(31, 63, 63);
        send_set_time(24, 60, 60);
        send_set_time(0, 0, 0);
        send_item(base_item(OP_SPARE_6));
        send_item(base_item(OP_SPARE_7));
        drain_results();
    endtask

    task automatic test_slow_receiver();
        send_idle_pct = 16;
        recv_idle_pct = 67;
        run_random(200);
        drain_results();
    endtask

    task automatic test_slow_sender();
        send_idle_pct = 67;
        recv_idle_pct = 16;
        run_random(200);
        drain_results();
    endtask

    task automatic test_back_to_back();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(180);
        drain_results();
    endtask

    // The receiver stops taking statuses for a long stretch while the
    // sender keeps offering beats, so the block backs up and drops its
    // request ready; the hold-off is counted down by the receiver process.
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge clk);
        hold_requests++;
        @(posedge clk);
        run_random(20);
        drain_results();
    endtask

    initial
    begin
        req_ch.valid <= 1'b0;
        req_ch.item  <= '0;
        send_idle_pct = 16;
        recv_idle_pct = 67;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_slow_receiver();
        test_slow_sender();
        test_back_to_back();
        test_output_stall();

        // Anything still in flight would show up within a walk's latency.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_status.size() == 0) begin
            $display("end of test: clean");
        end
        else begin
            if (pending_status.size() != 0) begin
                $display("%0t ns: status beats missing, expected %0d more, actual 0",
                         $time, pending_status.size());
            end
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/cdtk_pkg.sv
sv/cdtk_req_if.sv
sv/cdtk_rsp_if.sv
sv/cdtk_ctrl.sv
sv/cdtk_dpath.sv
sv/calendar_date_time_keeper.sv
sv/cdtk_checker.sv
tb/tb_calendar_date_time_keeper.sv
